FILE: src/tscc_pkg.sv
`default_nettype none

package tscc_pkg;

  // Width of every slot field in a request.
  localparam int unsigned SLOT_W = 21;

  // Width of the case tag stored with each bitmap word.
  localparam int unsigned EPOCH_W = 8;

  // Request kinds.
  localparam logic [1:0] KIND_ONESHOT  = 2'd0;
  localparam logic [1:0] KIND_PERIODIC = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] end_slot;
    logic [SLOT_W-1:0] period;
  } tscc_req_t;

  typedef struct packed {
    logic conflict;
    logic case_done;
  } tscc_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_OCC,
    ST_READ,
    ST_CHECK,
    ST_NEXT,
    ST_FIN
  } tscc_state_t;

endpackage

`default_nettype wire

FILE: src/tscc_div.sv
`default_nettype none

// Divider by a constant through a rounded-up reciprocal: the dividend is registered on
// start, then the quotient, then the remainder, and done pulses with both ready.
module tscc_div
  import tscc_pkg::*;
#(
  parameter int unsigned DIVISOR = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [SLOT_W-1:0]          dividend,
  output logic                            done,
  output logic [SLOT_W-1:0]               quotient,
  output logic [$clog2(DIVISOR)-1:0]      remainder
);

  localparam int unsigned RW = $clog2(DIVISOR);
  localparam int unsigned SH = SLOT_W + RW;
  localparam int unsigned MW = SLOT_W + 1;
  localparam int unsigned PW = SLOT_W + MW;

  // The reciprocal is rounded up with SLOT_W + RW fraction bits, which makes the
  // shifted product exact for every SLOT_W-bit dividend.
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic              stage1;
  logic              stage2;
  logic [SLOT_W-1:0] dvd;
  logic [SLOT_W-1:0] quo;
  logic [RW-1:0]     rem;
  logic [PW-1:0]     prod;
  logic [SLOT_W-1:0] back;

  // Reciprocal product for the quotient, then the part left over.
  always_comb begin
    prod = PW'(dvd) * PW'(RECIP);
    back = dvd - quo * SLOT_W'(DIVISOR);
  end

  // Control: a two-stage pipe, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  // Datapath: capture the dividend, then the quotient, then the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (stage1) begin
      quo <= SLOT_W'(prod >> SH);
    end
    if (stage2) begin
      rem <= RW'(back);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: src/time_slot_conflict_checker.sv
`default_nettype none

// Channel   Payload     Handshake              Direction
// req       tscc_req_t  req_valid / req_stall  in
// res       tscc_res_t  res_valid / res_stall  out
//
// A request is taken in ST_IDLE, and its result is loaded into the output register in ST_FIN.
// A reservation adds a divider pass for the start slot, a second one for the nonzero period
// of a periodic request, then ST_OCC and ST_NEXT per occurrence and ST_READ and ST_CHECK per word.
// The bitmap is one memory port, read then written per word, which sets the marking rate.
// After reset, and after every 255th end-of-case request, a clearing pass that writes
// each of the WORD_COUNT bitmap words in turn runs before the next request is taken.
// A result waits in the output register under res_stall; the next request is still taken.
module time_slot_conflict_checker
  import tscc_pkg::*;
#(
  parameter int unsigned HORIZON_SLOTS = 1048576,
  parameter int unsigned WORD_BITS     = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire tscc_req_t req_data,
  output logic           res_valid,
  input  wire logic      res_stall,
  output tscc_res_t      res_data
);

  localparam int unsigned WORD_COUNT = (HORIZON_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BB = $clog2(WORD_BITS);
  localparam int unsigned CB = $clog2(WORD_BITS + 1);
  localparam int unsigned HB = $clog2(HORIZON_SLOTS + 1);
  localparam int unsigned SW = ((HB > SLOT_W) ? HB : SLOT_W) + 2;

  // Bitmap memory; a word whose tag differs from the current epoch reads as free.
  logic [EPOCH_W-1:0]   tag_mem  [WORD_COUNT];
  logic [WORD_BITS-1:0] data_mem [WORD_COUNT];
  logic [EPOCH_W-1:0]   rd_tag;
  logic [WORD_BITS-1:0] rd_data;

  logic                 mem_we;
  logic                 mem_re;
  logic [WA-1:0]        mem_addr;
  logic [EPOCH_W-1:0]   mem_wtag;
  logic [WORD_BITS-1:0] mem_wdata;

  // Control registers.
  tscc_state_t        state, state_next;
  logic [WA-1:0]      clr_cnt, clr_cnt_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic               conflict_seen, conflict_seen_next;
  logic               need_clear, need_clear_next;
  logic               phase, phase_next;
  logic               res_valid_next;

  // Datapath registers.
  tscc_res_t       res_data_next;
  logic [1:0]      kind_r, kind_r_next;
  logic [SLOT_W-1:0] span_len, span_len_next;
  logic [SLOT_W-1:0] period_r, period_r_next;
  logic [SW-1:0]   occ_lo, occ_lo_next;
  logic [SW-1:0]   occ_word, occ_word_next;
  logic [BB-1:0]   occ_bit, occ_bit_next;
  logic [SLOT_W-1:0] pq, pq_next;
  logic [BB-1:0]   pr, pr_next;
  logic [WA-1:0]   cur_word, cur_word_next;
  logic [BB-1:0]   cur_bit, cur_bit_next;
  logic [SLOT_W-1:0] rem, rem_next;
  logic            pend_end, pend_end_next;
  logic            pend_conf, pend_conf_next;

  // Shared divider by WORD_BITS.
  logic              div_start;
  logic [SLOT_W-1:0] div_dividend;
  logic              div_done;
  logic [SLOT_W-1:0] div_quo;
  logic [BB-1:0]     div_rem;

  tscc_div #(
    .DIVISOR (WORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Chunk of the current word to mark, and its mask.
  logic [CB-1:0]        avail;
  logic [CB-1:0]        chunk;
  logic [WORD_BITS:0]   ones_w;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] word_now;
  logic [SW-1:0]        room;
  logic [BB:0]          bsum;

  always_comb begin
    avail    = CB'(WORD_BITS) - CB'(cur_bit);
    chunk    = (rem < SLOT_W'(avail)) ? CB'(rem) : avail;
    ones_w   = ((WORD_BITS+1)'(1) << chunk) - (WORD_BITS+1)'(1);
    mask     = ones_w[WORD_BITS-1:0] << cur_bit;
    word_now = (rd_tag == epoch) ? rd_data : '0;
    room     = SW'(HORIZON_SLOTS) - occ_lo;
    bsum     = (BB+1)'(occ_bit) + (BB+1)'(pr);
  end

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_next         = state;
    clr_cnt_next       = clr_cnt;
    epoch_next         = epoch;
    conflict_seen_next = conflict_seen;
    need_clear_next    = need_clear;
    phase_next         = phase;
    kind_r_next        = kind_r;
    span_len_next      = span_len;
    period_r_next      = period_r;
    occ_lo_next        = occ_lo;
    occ_word_next      = occ_word;
    occ_bit_next       = occ_bit;
    pq_next            = pq;
    pr_next            = pr;
    cur_word_next      = cur_word;
    cur_bit_next       = cur_bit;
    rem_next           = rem;
    pend_end_next      = pend_end;
    pend_conf_next     = pend_conf;
    res_data_next      = res_data;
    res_valid_next     = res_valid && res_stall;
    div_start          = 1'b0;
    div_dividend       = (state == ST_IDLE) ? req_data.start_slot : period_r;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_addr           = (state == ST_CLEAR) ? clr_cnt : cur_word;
    mem_wtag           = epoch;
    mem_wdata          = word_now | mask;
    req_stall          = (state != ST_IDLE);

    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wtag     = '0;
        mem_wdata    = '0;
        clr_cnt_next = clr_cnt + WA'(1);
        if (clr_cnt == WA'(WORD_COUNT - 1)) begin
          clr_cnt_next = '0;
          epoch_next   = EPOCH_W'(1);
          state_next   = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          kind_r_next   = req_data.kind;
          span_len_next = req_data.end_slot - req_data.start_slot;
          period_r_next = req_data.period;
          occ_lo_next   = SW'(req_data.start_slot);
          pend_end_next = 1'b0;
          if (req_data.kind == KIND_END) begin
            pend_end_next      = 1'b1;
            pend_conf_next     = conflict_seen;
            conflict_seen_next = 1'b0;
            if (epoch == '1) begin
              need_clear_next = 1'b1;
            end else begin
              epoch_next = epoch + EPOCH_W'(1);
            end
            state_next = ST_FIN;
          end else if ((req_data.kind == KIND_ONESHOT || req_data.kind == KIND_PERIODIC) &&
                       !conflict_seen && (req_data.end_slot > req_data.start_slot)) begin
            div_start  = 1'b1;
            phase_next = 1'b0;
            state_next = ST_DIV;
          end else begin
            state_next = ST_FIN;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          if (!phase) begin
            occ_word_next = SW'(div_quo);
            occ_bit_next  = div_rem;
            if (kind_r == KIND_PERIODIC && period_r != '0) begin
              phase_next = 1'b1;
              div_start  = 1'b1;
            end else begin
              state_next = ST_OCC;
            end
          end else begin
            pq_next    = div_quo;
            pr_next    = div_rem;
            state_next = ST_OCC;
          end
        end
      end

      // Start one occurrence, clipped at the horizon.
      ST_OCC: begin
        if (occ_lo >= SW'(HORIZON_SLOTS)) begin
          state_next = ST_FIN;
        end else begin
          rem_next      = (SW'(span_len) < room) ? span_len : SLOT_W'(room);
          cur_word_next = occ_word[WA-1:0];
          cur_bit_next  = occ_bit;
          state_next    = ST_READ;
        end
      end

      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_CHECK;
      end

      // Check the chunk against the stored word, and mark it if it is free.
      ST_CHECK: begin
        if ((word_now & mask) != '0) begin
          conflict_seen_next = 1'b1;
          state_next         = ST_FIN;
        end else begin
          mem_we        = 1'b1;
          rem_next      = rem - SLOT_W'(chunk);
          cur_word_next = cur_word + WA'(1);
          cur_bit_next  = '0;
          state_next    = (rem == SLOT_W'(chunk)) ? ST_NEXT : ST_READ;
        end
      end

      // Step to the next occurrence by one period, or finish if the request has no period.
      ST_NEXT: begin
        if (kind_r != KIND_PERIODIC || period_r == '0) begin
          state_next = ST_FIN;
        end else begin
          occ_lo_next = occ_lo + SW'(period_r);
          if (bsum >= (BB+1)'(WORD_BITS)) begin
            occ_bit_next  = BB'(bsum - (BB+1)'(WORD_BITS));
            occ_word_next = occ_word + SW'(pq) + SW'(1);
          end else begin
            occ_bit_next  = BB'(bsum);
            occ_word_next = occ_word + SW'(pq);
          end
          state_next = ST_OCC;
        end
      end

      // Hand the result to the output register once it is free.
      ST_FIN: begin
        if (!res_valid || !res_stall) begin
          res_valid_next = 1'b1;
          if (pend_end) begin
            res_data_next.conflict  = pend_conf;
            res_data_next.case_done = 1'b1;
          end else begin
            res_data_next.conflict  = conflict_seen;
            res_data_next.case_done = 1'b0;
          end
          need_clear_next = 1'b0;
          state_next      = need_clear ? ST_CLEAR : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      epoch         <= '0;
      conflict_seen <= 1'b0;
      need_clear    <= 1'b0;
      phase         <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clr_cnt       <= clr_cnt_next;
      epoch         <= epoch_next;
      conflict_seen <= conflict_seen_next;
      need_clear    <= need_clear_next;
      phase         <= phase_next;
      res_valid     <= res_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    kind_r    <= kind_r_next;
    span_len  <= span_len_next;
    period_r  <= period_r_next;
    occ_lo    <= occ_lo_next;
    occ_word  <= occ_word_next;
    occ_bit   <= occ_bit_next;
    pq        <= pq_next;
    pr        <= pr_next;
    cur_word  <= cur_word_next;
    cur_bit   <= cur_bit_next;
    rem       <= rem_next;
    pend_end  <= pend_end_next;
    pend_conf <= pend_conf_next;
    res_data  <= res_data_next;
  end

  // Bitmap memory port: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_addr]  <= mem_wtag;
      data_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_tag  <= tag_mem[mem_addr];
      rd_data <= data_mem[mem_addr];
    end
  end

endmodule

`default_nettype wire
